@@ src/biq_pkg.sv @@
`default_nettype none

package biq_pkg;

  // apb register map, one 32-bit word per register
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_FILTER_MODE = 3'd0;
  localparam logic [2:0] REG_BYPASS      = 3'd1;
  localparam logic [2:0] REG_COEF_A0     = 3'd2;
  localparam logic [2:0] REG_COEF_A1     = 3'd3;
  localparam logic [2:0] REG_COEF_B1     = 3'd4;
  localparam logic [2:0] REG_COEF_B2     = 3'd5;

  localparam logic [1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [1:0] MODE_BANDSTOP = 2'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic       bypass;
  } ctrl_t;

endpackage

`default_nettype wire

@@ src/biq_regs.sv @@
`default_nettype none

module biq_regs #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [biq_pkg::ADDR_W-1:0]  paddr,
  input  logic [biq_pkg::DATA_W-1:0]  pwdata,
  output logic [biq_pkg::DATA_W-1:0]  prdata,
  output biq_pkg::ctrl_t              ctrl,
  output logic signed [COEF_WIDTH-1:0] coef_a0,
  output logic signed [COEF_WIDTH-1:0] coef_a1,
  output logic signed [COEF_WIDTH-1:0] coef_b1,
  output logic signed [COEF_WIDTH-1:0] coef_b2
);
  import biq_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode   <= MODE_LOWPASS;
      ctrl.bypass <= 1'b1;
      coef_a0     <= '0;
      coef_a1     <= '0;
      coef_b1     <= '0;
      coef_b2     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FILTER_MODE: ctrl.mode   <= pwdata[1:0];
        REG_BYPASS:      ctrl.bypass <= pwdata[0];
        REG_COEF_A0:     coef_a0     <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_A1:     coef_a1     <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_B1:     coef_b1     <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_B2:     coef_b2     <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FILTER_MODE: prdata = DATA_W'(ctrl.mode);
      REG_BYPASS:      prdata = DATA_W'(ctrl.bypass);
      REG_COEF_A0:     prdata = DATA_W'(coef_a0);
      REG_COEF_A1:     prdata = DATA_W'(coef_a1);
      REG_COEF_B1:     prdata = DATA_W'(coef_b1);
      REG_COEF_B2:     prdata = DATA_W'(coef_b2);
      default:         prdata = '0;
    endcase
  end

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && idx == REG_FILTER_MODE) |=> ctrl.mode == $past(pwdata[1:0]))
    else $error("filter mode write lost");

  a_bypass_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && idx == REG_BYPASS) |=> ctrl.bypass == $past(pwdata[0]))
    else $error("bypass write lost");

  a_no_write_hold: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> $stable(ctrl) && $stable(coef_a0) && $stable(coef_b2))
    else $error("register changed without a write");

endmodule

`default_nettype wire

@@ src/biq_datapath.sv @@
`default_nettype none

module biq_datapath #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  biq_pkg::ctrl_t                ctrl,
  input  logic signed [COEF_WIDTH-1:0]   coef_a0,
  input  logic signed [COEF_WIDTH-1:0]   coef_a1,
  input  logic signed [COEF_WIDTH-1:0]   coef_b1,
  input  logic signed [COEF_WIDTH-1:0]   coef_b2,
  output logic signed [SAMPLE_WIDTH-1:0] y
);
  import biq_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CF    = COEF_WIDTH - 4;
  localparam int ACC_W = SAMPLE_WIDTH + COEF_WIDTH + 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SW-1:0]    x_prev1, x_prev2, y_prev1, y_prev2;
  logic signed [SW:0]      sum_x, diff_xy, a1_op;
  logic signed [ACC_W-1:0] p0, p1, p2, p3, acc, shifted;
  logic signed [SW-1:0]    y_filt, y_res;
  logic                    bandstop;

  assign bandstop = (ctrl.mode == MODE_BANDSTOP);

  assign sum_x   = {x[SW-1], x} + {x_prev2[SW-1], x_prev2};
  assign diff_xy = {x_prev1[SW-1], x_prev1} - {y_prev1[SW-1], y_prev1};
  assign a1_op   = bandstop ? diff_xy : {x_prev1[SW-1], x_prev1};

  assign p0 = ACC_W'(coef_a0) * ACC_W'(sum_x);
  assign p1 = ACC_W'(coef_a1) * ACC_W'(a1_op);
  assign p2 = bandstop ? '0 : ACC_W'(coef_b1) * ACC_W'(y_prev1);
  assign p3 = ACC_W'(coef_b2) * ACC_W'(y_prev2);

  // round half up at the coefficient fraction point
  assign acc     = p0 + p1 - p2 - p3 + ROUND_HALF;
  assign shifted = acc >>> CF;

  always_comb begin
    if (shifted > SAT_HI) begin
      y_filt = SAT_HI[SW-1:0];
    end else if (shifted < SAT_LO) begin
      y_filt = SAT_LO[SW-1:0];
    end else begin
      y_filt = shifted[SW-1:0];
    end
  end

  always_comb begin
    case (ctrl.mode)
      MODE_LOWPASS:  y_res = y_filt;
      MODE_BANDSTOP: y_res = y_filt;
      default:       y_res = '0;
    endcase
  end

  assign y = ctrl.bypass ? x : y_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_prev1 <= '0;
      x_prev2 <= '0;
      y_prev1 <= '0;
      y_prev2 <= '0;
    end else if (advance && !ctrl.bypass) begin
      x_prev2 <= x_prev1;
      x_prev1 <= x;
      y_prev2 <= y_prev1;
      y_prev1 <= y_res;
    end
  end

  a_bypass_keeps_history: assert property (@(posedge clk) disable iff (rst)
    (advance && ctrl.bypass) |=> $stable(x_prev1) && $stable(y_prev1) && $stable(y_prev2))
    else $error("history moved during bypass");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    (advance && !ctrl.bypass) |=> x_prev2 == $past(x_prev1) && y_prev2 == $past(y_prev1))
    else $error("history did not shift");

  a_unused_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && !ctrl.bypass && ctrl.mode != MODE_LOWPASS && ctrl.mode != MODE_BANDSTOP)
      |=> y_prev1 == '0)
    else $error("unused mode fed a nonzero output back");

endmodule

`default_nettype wire

@@ src/biquad_iir_filter_core.sv @@
`default_nettype none

// channel   | handshake                        | payload
// ----------+----------------------------------+------------------------
// samples   | sample_valid / sample_ready      | sample_in  (signed)
// results   | result_valid / result_ready      | sample_out (signed)
// config    | psel penable pwrite pready (apb) | paddr pwdata / prdata
//
// one sample per cycle while result_ready is high; a beat is held in the input register
// and its result in the result register. the rate is set by the y_prev1 feedback loop:
// four multiplies, the sum, rounding and saturation all sit between the input register
// and the result register. the input register and the result register each hold one
// beat, so a new sample is taken while a finished result waits on result_ready
// synchronous reset clears the history, the registers (bypass set) and both valids

module biquad_iir_filter_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [biq_pkg::ADDR_W-1:0]    paddr,
  input  logic [biq_pkg::DATA_W-1:0]    pwdata,
  output logic [biq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import biq_pkg::*;

  ctrl_t                         ctrl;
  logic signed [COEF_WIDTH-1:0]   coef_a0, coef_a1, coef_b1, coef_b2;
  logic                          s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic                          advance;

  assign pready = 1'b1;

  biq_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .ctrl    (ctrl),
    .coef_a0 (coef_a0),
    .coef_a1 (coef_a1),
    .coef_b1 (coef_b1),
    .coef_b2 (coef_b2)
  );

  // the input register moves into the result register when that one is empty or drained
  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_sample <= sample_in;
    end
  end

  biq_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x       (s1_sample),
    .ctrl    (ctrl),
    .coef_a0 (coef_a0),
    .coef_a1 (coef_a1),
    .coef_b1 (coef_b1),
    .coef_b2 (coef_b2),
    .y       (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y;
    end
  end

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("beat lost between input and result register");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid && $stable(s1_sample))
    else $error("input register overwritten while stalled");

  a_no_advance_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
